[hdl/page_table_lookup_walker_unit_macros.svh]
// Assertion helpers used by the bound checker.
`ifndef PAGE_TABLE_LOOKUP_WALKER_UNIT_MACROS_SVH
`define PAGE_TABLE_LOOKUP_WALKER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PLTW_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("page table walker check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PLTW_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("page table walker check failed");

`endif

[hdl/pltw_pkg.sv]
package pltw_pkg;

    // Input beat kinds
    typedef enum logic {
        KIND_LOOKUP   = 1'b0,
        KIND_RESPONSE = 1'b1
    } in_kind_t;

    // Result beat kinds
    typedef enum logic [1:0] {
        RESULT_READ_REQ  = 2'd0,
        RESULT_WALK_DONE = 2'd1,
        RESULT_PROTO_ERR = 2'd2
    } result_kind_t;

    // Table levels
    localparam logic [1:0] LEVEL_ROOT = 2'd0;
    localparam logic [1:0] LEVEL_PTR  = 2'd1;
    localparam logic [1:0] LEVEL_DIR  = 2'd2;
    localparam logic [1:0] LEVEL_LEAF = 2'd3;

    // Entry flag bit positions
    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_LARGE_BIT   = 7;
    localparam int ENTRY_SWAPPED_BIT = 9;

    localparam int BASE_W  = 52;
    localparam int VA_W    = 48;
    localparam int ENTRY_W = 64;
    localparam int ADDR_W  = 63;
    localparam int PN_W    = 36;
    localparam int IDX_W   = 9;

    typedef struct packed {
        in_kind_t            kind;
        logic [VA_W-1:0]     virt_addr;
        logic [ENTRY_W-1:0]  read_data;
    } in_beat_t;

    typedef struct packed {
        result_kind_t        result_kind;
        logic [ADDR_W-1:0]   read_addr;
        logic                is_mapped;
        logic                leaf_found;
        logic                large_page;
        logic [ENTRY_W-1:0]  last_entry;
        logic [1:0]          stop_level;
    } out_beat_t;

    // Walk state carried between beats
    typedef struct packed {
        logic                busy;
        logic [1:0]          level;
        logic [PN_W-1:0]     page_number;
    } walk_state_t;

endpackage

[hdl/pltw_step.sv]
module pltw_step
(
    input  pltw_pkg::in_beat_t                in_beat,
    input  pltw_pkg::walk_state_t             state,
    input  logic [pltw_pkg::BASE_W-1:0]       root_table_base,
    output pltw_pkg::out_beat_t               result,
    output pltw_pkg::walk_state_t             state_next
);

    logic [pltw_pkg::ENTRY_W-1:0] entry;
    logic                         present;
    logic                         swapped;
    logic                         large_flag;
    logic [1:0]                   level_up;
    logic [pltw_pkg::IDX_W-1:0]   next_index;
    logic [pltw_pkg::IDX_W-1:0]   root_index;

    assign entry      = in_beat.read_data;
    assign present    = entry[pltw_pkg::ENTRY_PRESENT_BIT];
    assign swapped    = entry[pltw_pkg::ENTRY_SWAPPED_BIT];
    assign large_flag = entry[pltw_pkg::ENTRY_LARGE_BIT];
    assign level_up   = state.level + 2'd1;
    assign root_index = in_beat.virt_addr[47:39];

    // Index for the table one level down, from the saved page number
    always_comb
    begin
        case (level_up)
            pltw_pkg::LEVEL_PTR:  next_index = state.page_number[26:18];
            pltw_pkg::LEVEL_DIR:  next_index = state.page_number[17:9];
            pltw_pkg::LEVEL_LEAF: next_index = state.page_number[8:0];
            default:              next_index = state.page_number[35:27];
        endcase
    end

    // One beat of the walk
    always_comb
    begin
        result      = '0;
        state_next  = state;
        case (in_beat.kind)
            pltw_pkg::KIND_LOOKUP:
            begin
                if (state.busy)
                begin
                    result.result_kind = pltw_pkg::RESULT_PROTO_ERR;
                end
                else
                begin
                    state_next.busy        = 1'b1;
                    state_next.level       = pltw_pkg::LEVEL_ROOT;
                    state_next.page_number = in_beat.virt_addr[47:12];
                    result.result_kind     = pltw_pkg::RESULT_READ_REQ;
                    result.read_addr       = {11'd0, root_table_base}
                                           + {51'd0, root_index, 3'b000};
                end
            end
            pltw_pkg::KIND_RESPONSE:
            begin
                if (!state.busy)
                begin
                    result.result_kind = pltw_pkg::RESULT_PROTO_ERR;
                end
                else if (state.level == pltw_pkg::LEVEL_LEAF)
                begin
                    // leaf entry: swapped still counts as found
                    state_next.busy    = 1'b0;
                    result.result_kind = pltw_pkg::RESULT_WALK_DONE;
                    result.is_mapped   = present;
                    result.leaf_found  = present | swapped;
                    result.last_entry  = entry;
                    result.stop_level  = pltw_pkg::LEVEL_LEAF;
                end
                else if (!present)
                begin
                    state_next.busy    = 1'b0;
                    result.result_kind = pltw_pkg::RESULT_WALK_DONE;
                    result.last_entry  = entry;
                    result.stop_level  = state.level;
                end
                else if (state.level == pltw_pkg::LEVEL_DIR && large_flag)
                begin
                    // 2 MB page
                    state_next.busy    = 1'b0;
                    result.result_kind = pltw_pkg::RESULT_WALK_DONE;
                    result.is_mapped   = 1'b1;
                    result.large_page  = 1'b1;
                    result.last_entry  = entry;
                    result.stop_level  = pltw_pkg::LEVEL_DIR;
                end
                else
                begin
                    // low 12 bits of the table base are clear, so no carry
                    state_next.level   = level_up;
                    result.result_kind = pltw_pkg::RESULT_READ_REQ;
                    result.read_addr   = {entry[62:12], next_index, 3'b000};
                end
            end
            default:
            begin
                result.result_kind = pltw_pkg::RESULT_PROTO_ERR;
            end
        endcase
    end

endmodule

[hdl/page_table_lookup_walker_unit.sv]
// Four-level page table walker, lookup only.
// Input channel (in_valid/in_ready/in_data): a beat is either a lookup with a
// 48-bit virtual address or a memory response carrying one 64-bit entry.
// Output channel (out_valid/out_ready/out_data): exactly one beat per input
// beat: a read request for the next entry, a walk result, or a protocol error
// for a lookup while a walk is open or a response with no walk open.
// Configuration: cfg_write_en/cfg_write_data load the root table base at once.
// Result: registered, shown in the cycle after the input beat is taken.
// Throughput: one beat per cycle unless stalled; decode, mask and one 63-bit
// add sit between the walk state registers and the single output register.
// Stall: in_ready = !out_valid || out_ready, so a stalled receiver holds the
// output register and the input side waits; no beat is dropped.
// Reset: walker idle, level and saved page number cleared, root base zero,
// output empty.
module page_table_lookup_walker_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pltw_pkg::in_beat_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pltw_pkg::out_beat_t           out_data,
    input  logic                          cfg_write_en,
    input  logic [pltw_pkg::BASE_W-1:0]   cfg_write_data
);

    logic [pltw_pkg::BASE_W-1:0] root_base_reg;
    pltw_pkg::walk_state_t       state_reg;
    pltw_pkg::walk_state_t       state_next;
    pltw_pkg::out_beat_t         result_next;
    pltw_pkg::out_beat_t         result_reg;
    logic                        out_valid_reg;
    logic                        accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    pltw_step u_step
    (
        .in_beat         (in_data),
        .state           (state_reg),
        .root_table_base (root_base_reg),
        .result          (result_next),
        .state_next      (state_next)
    );

    // Root base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root_base_reg <= '0;
        else if (cfg_write_en)
            root_base_reg <= cfg_write_data;
    end

    // Walk state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

endmodule

[hdl/pltw_checker.sv]
`include "page_table_lookup_walker_unit_macros.svh"

module pltw_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  pltw_pkg::out_beat_t           out_data
);

    // A stalled result beat holds
    `PLTW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // Every accepted input beat yields a result beat next cycle
    `PLTW_ASSERT_NEXT(a_one_latency, in_valid && in_ready, out_valid)

    // Only requests carry an address
    `PLTW_ASSERT_NOW(a_addr_only_req,
        out_valid && out_data.result_kind != pltw_pkg::RESULT_READ_REQ,
        out_data.read_addr == '0)

    // Requests and errors carry no walk outcome
    `PLTW_ASSERT_NOW(a_no_outcome,
        out_valid && out_data.result_kind != pltw_pkg::RESULT_WALK_DONE,
        !out_data.is_mapped && !out_data.leaf_found && !out_data.large_page
        && out_data.last_entry == '0 && out_data.stop_level == '0)

    // A large page only ends at the directory level, mapped
    `PLTW_ASSERT_NOW(a_large_dir,
        out_valid && out_data.large_page,
        out_data.is_mapped && out_data.stop_level == pltw_pkg::LEVEL_DIR)

endmodule

bind page_table_lookup_walker_unit pltw_checker u_pltw_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
